### design/smvl_pkg.sv
`default_nettype none
package smvl_pkg;

  localparam int FRACTION_BITS = 12;
  localparam int ONE_Q         = 1 << FRACTION_BITS;

  // field widths
  localparam int ERR_W    = 16;
  localparam int DT_W     = 20;
  localparam int VEL_W    = 16;
  localparam int LIM_W    = 15;
  localparam int S_ANG_W  = 24;
  localparam int GAIN_W   = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 104;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_ROBOT_MODE    = 3'd0,
    REG_SURFACE_SLOPE = 3'd1,
    REG_LINEAR_GAINS  = 3'd2,
    REG_LATERAL_GAINS = 3'd3,
    REG_ANGULAR_GAINS = 3'd4,
    REG_BOUNDARY_RECP = 3'd5,
    REG_LIN_LAT_LIMS  = 3'd6,
    REG_ANGULAR_LIMIT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        robot_mode;
    logic [15:0] surface_slope;
    logic [31:0] linear_gains;
    logic [31:0] lateral_gains;
    logic [31:0] angular_gains;
    logic [15:0] boundary_reciprocal;
    logic [31:0] linear_lateral_limits;
    logic [14:0] angular_limit;
  } cfg_t;

  localparam logic        RST_ROBOT_MODE    = 1'b0;
  localparam logic [15:0] RST_SURFACE_SLOPE = 16'd4096;
  localparam logic [31:0] RST_LINEAR_GAINS  = 32'd268436275;
  localparam logic [31:0] RST_LATERAL_GAINS = 32'd134218547;
  localparam logic [31:0] RST_ANGULAR_GAINS = 32'd268437504;
  localparam logic [15:0] RST_BOUNDARY_RECP = 16'd40960;
  localparam logic [31:0] RST_LIN_LAT_LIMS  = 32'd80479436;
  localparam logic [14:0] RST_ANGULAR_LIMIT = 15'd4096;

  // serial multiplier: signed a times unsigned b, two bits of b per cycle
  localparam int MUL_AW     = 24;
  localparam int MUL_BW     = 20;
  localparam int MUL_PW     = MUL_AW + MUL_BW;
  localparam int MUL_STEPS  = MUL_BW / 2;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);

  // serial restoring divider, one quotient bit per cycle
  localparam int DIV_NW     = 36;
  localparam int DIV_DW     = 20;
  localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);

  localparam int QW     = FRACTION_BITS + 2;
  localparam int LAW_W  = MUL_PW - FRACTION_BITS;
  localparam int U_W    = LAW_W + 1;
  localparam int SURF_W = DIV_NW + 2;

  localparam logic signed [MUL_PW-1:0] P_ONE  = MUL_PW'(ONE_Q);
  localparam logic signed [MUL_PW-1:0] P_MONE = MUL_PW'(-ONE_Q);
  localparam logic signed [SURF_W-1:0] SA_MAX = SURF_W'((1 << (S_ANG_W - 1)) - 1);
  localparam logic signed [SURF_W-1:0] SA_MIN = SURF_W'(-(1 << (S_ANG_W - 1)));

  localparam logic [DT_W-1:0]   DT_MIN      = DT_W'(100);
  localparam logic [MUL_BW-1:0] MICRO_SCALE = MUL_BW'(1000000);

  // heading wrap
  localparam longint PI_AT_32  = 64'd13493037705;
  localparam int     PI_Q      = int'((PI_AT_32 + (longint'(1) << (31 - FRACTION_BITS)))
                                      >> (32 - FRACTION_BITS));
  localparam int     PERIOD    = 2 * PI_Q;
  localparam int     ERR_SPAN  = 1 << (ERR_W - 1);
  localparam int     WRAP_OFF  = PERIOD * ((ERR_SPAN + PERIOD - 1) / PERIOD);
  localparam int     WRAP_BASE = PI_Q + WRAP_OFF;
  localparam int     WRAP_W    = $clog2(WRAP_BASE + ERR_SPAN + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_SLOPE,
    ST_DERIV,
    ST_DIVIDE,
    ST_SURF,
    ST_LAW_Q,
    ST_LAW_E,
    ST_LAW_K,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AX_FWD,
    AX_LAT,
    AX_ANG
  } axis_t;

endpackage
`default_nettype wire

### design/smvl_regs.sv
`default_nettype none
module smvl_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [smvl_pkg::CFG_AW-1:0]     paddr,
  input  wire logic [smvl_pkg::CFG_DW-1:0]     pwdata,
  output logic      [smvl_pkg::CFG_DW-1:0]     prdata,
  output logic                                 pready,
  output smvl_pkg::cfg_t                       cfg
);

  smvl_pkg::cfg_t   cfg_r;
  smvl_pkg::reg_idx_t idx;

  assign idx    = smvl_pkg::reg_idx_t'(paddr[smvl_pkg::CFG_AW-1:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.robot_mode            <= smvl_pkg::RST_ROBOT_MODE;
      cfg_r.surface_slope         <= smvl_pkg::RST_SURFACE_SLOPE;
      cfg_r.linear_gains          <= smvl_pkg::RST_LINEAR_GAINS;
      cfg_r.lateral_gains         <= smvl_pkg::RST_LATERAL_GAINS;
      cfg_r.angular_gains         <= smvl_pkg::RST_ANGULAR_GAINS;
      cfg_r.boundary_reciprocal   <= smvl_pkg::RST_BOUNDARY_RECP;
      cfg_r.linear_lateral_limits <= smvl_pkg::RST_LIN_LAT_LIMS;
      cfg_r.angular_limit         <= smvl_pkg::RST_ANGULAR_LIMIT;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        smvl_pkg::REG_ROBOT_MODE:    cfg_r.robot_mode            <= pwdata[0];
        smvl_pkg::REG_SURFACE_SLOPE: cfg_r.surface_slope         <= pwdata[15:0];
        smvl_pkg::REG_LINEAR_GAINS:  cfg_r.linear_gains          <= pwdata;
        smvl_pkg::REG_LATERAL_GAINS: cfg_r.lateral_gains         <= pwdata;
        smvl_pkg::REG_ANGULAR_GAINS: cfg_r.angular_gains         <= pwdata;
        smvl_pkg::REG_BOUNDARY_RECP: cfg_r.boundary_reciprocal   <= pwdata[15:0];
        smvl_pkg::REG_LIN_LAT_LIMS:  cfg_r.linear_lateral_limits <= pwdata;
        smvl_pkg::REG_ANGULAR_LIMIT: cfg_r.angular_limit         <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      smvl_pkg::REG_ROBOT_MODE:    prdata = 32'(cfg_r.robot_mode);
      smvl_pkg::REG_SURFACE_SLOPE: prdata = 32'(cfg_r.surface_slope);
      smvl_pkg::REG_LINEAR_GAINS:  prdata = cfg_r.linear_gains;
      smvl_pkg::REG_LATERAL_GAINS: prdata = cfg_r.lateral_gains;
      smvl_pkg::REG_ANGULAR_GAINS: prdata = cfg_r.angular_gains;
      smvl_pkg::REG_BOUNDARY_RECP: prdata = 32'(cfg_r.boundary_reciprocal);
      smvl_pkg::REG_LIN_LAT_LIMS:  prdata = cfg_r.linear_lateral_limits;
      smvl_pkg::REG_ANGULAR_LIMIT: prdata = 32'(cfg_r.angular_limit);
      default:                     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/smvl_mul.sv
`default_nettype none
module smvl_mul (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [smvl_pkg::MUL_AW-1:0]  a,
  input  wire logic        [smvl_pkg::MUL_BW-1:0]  b,
  output logic                                     done,
  output logic signed      [smvl_pkg::MUL_PW-1:0]  prod
);

  localparam int AW = smvl_pkg::MUL_AW;
  localparam int BW = smvl_pkg::MUL_BW;
  localparam int CW = smvl_pkg::MUL_CNT_W;

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic signed [AW-1:0] a_r;
  logic [BW-1:0]     b_r;
  logic signed [AW:0]   hi_r;
  logic [BW-1:0]     lo_r;

  logic signed [AW+2:0] a_ext;
  logic signed [AW+2:0] pp;
  logic signed [AW+2:0] sum;

  // radix-4 digit: a*d for d in 0..3, then shift the partial sum right two bits
  always_comb begin
    a_ext = (AW+3)'(a_r);
    pp    = '0;
    if (b_r[0]) pp = pp + a_ext;
    if (b_r[1]) pp = pp + (a_ext <<< 1);
    sum   = (AW+3)'(hi_r) + pp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(smvl_pkg::MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r  <= a;
      b_r  <= b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (busy_r) begin
      hi_r <= sum[AW+2:2];
      lo_r <= {sum[1:0], lo_r[BW-1:2]};
      b_r  <= {2'b00, b_r[BW-1:2]};
    end
  end

  assign done = done_r;
  assign prod = signed'({hi_r[AW-1:0], lo_r});

endmodule
`default_nettype wire

### design/smvl_div.sv
`default_nettype none
module smvl_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [smvl_pkg::DIV_NW-1:0]   dividend,
  input  wire logic [smvl_pkg::DIV_DW-1:0]   divisor,
  output logic                               done,
  output logic      [smvl_pkg::DIV_NW-1:0]   quotient,
  output logic      [smvl_pkg::DIV_DW-1:0]   remainder
);

  localparam int NW = smvl_pkg::DIV_NW;
  localparam int DW = smvl_pkg::DIV_DW;
  localparam int CW = smvl_pkg::DIV_CNT_W;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvs_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;

  logic [DW:0]   shifted;
  logic [DW+1:0] trial;
  logic          fits;

  always_comb begin
    shifted = {rem_r, quo_r[NW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    fits    = !trial[DW+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DW-1:0] : shifted[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

### design/sliding_mode_velocity_law.sv
`default_nettype none
// Sliding-mode velocity law with a boundary layer: one result beat per input beat, computing
// u = eta*s + k*sat(s/phi) per axis in Q.12 fixed point and clamping to the axis limits. All
// products go through one shared serial multiplier (two bits per cycle) and the derivative
// quotient and heading wrap through one serial divider (one bit per cycle). An input beat is
// taken only in the idle state, so one item is finished before the next is accepted; a new
// beat may be taken while the previous result still waits in the output register. Registers
// are to be written only while no tick is in flight; the block itself does not enforce this.
module sliding_mode_velocity_law (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // error_x, error_y, error_heading, elapsed_us, zero pad
  input  wire logic [smvl_pkg::IN_TDATA_W-1:0]       in_tdata,
  // new_plan
  input  wire logic                                  in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // velocity_forward, velocity_lateral, velocity_angular, surface_forward,
  // surface_lateral, surface_angular
  output logic      [smvl_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [smvl_pkg::CFG_AW-1:0]           cfg_paddr,
  input  wire logic [smvl_pkg::CFG_DW-1:0]           cfg_pwdata,
  output logic      [smvl_pkg::CFG_DW-1:0]           cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int EW = smvl_pkg::ERR_W;
  localparam int TW = smvl_pkg::DT_W;

  smvl_pkg::cfg_t cfg;

  smvl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input fields
  logic signed [EW-1:0] in_ex, in_ey, in_eh;
  logic [TW-1:0]        in_dt;
  assign in_ex = signed'(in_tdata[EW-1:0]);
  assign in_ey = signed'(in_tdata[2*EW-1:EW]);
  assign in_eh = signed'(in_tdata[3*EW-1:2*EW]);
  assign in_dt = in_tdata[3*EW+TW-1:3*EW];

  // multiplier and divider
  logic                                     mul_start, mul_done;
  logic signed [smvl_pkg::MUL_AW-1:0]       mul_a;
  logic        [smvl_pkg::MUL_BW-1:0]       mul_b;
  logic signed [smvl_pkg::MUL_PW-1:0]       mul_prod;
  logic                                     div_start, div_done;
  logic        [smvl_pkg::DIV_NW-1:0]       div_num;
  logic        [smvl_pkg::DIV_DW-1:0]       div_den;
  logic        [smvl_pkg::DIV_NW-1:0]       div_quo;
  logic        [smvl_pkg::DIV_DW-1:0]       div_rem;

  smvl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  smvl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // control state
  smvl_pkg::state_t state_r, state_nxt;
  smvl_pkg::axis_t  axis_r, axis_nxt;
  logic             issued_r, issued_nxt;
  logic             armed_r, armed_nxt;
  logic signed [EW-1:0] prev_r, prev_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  // working registers
  logic signed [EW-1:0]                   ex_r, ex_nxt;
  logic signed [EW-1:0]                   ey_r, ey_nxt;
  logic [TW-1:0]                          dt_r, dt_nxt;
  logic signed [EW:0]                     diff_r, diff_nxt;
  logic [smvl_pkg::WRAP_W-1:0]            wrap_t_r, wrap_t_nxt;
  logic signed [smvl_pkg::S_ANG_W-1:0]    s_ang_r, s_ang_nxt;
  logic signed [smvl_pkg::LAW_W-1:0]      slope_r, slope_nxt;
  logic                                   neg_r, neg_nxt;
  logic [smvl_pkg::DIV_NW-1:0]            num_mag_r, num_mag_nxt;
  logic signed [smvl_pkg::QW-1:0]         q_r, q_nxt;
  logic signed [smvl_pkg::LAW_W-1:0]      t1_r, t1_nxt;
  logic signed [smvl_pkg::VEL_W-1:0]      vf_r, vf_nxt;
  logic signed [smvl_pkg::VEL_W-1:0]      vl_r, vl_nxt;
  logic signed [smvl_pkg::VEL_W-1:0]      va_r, va_nxt;
  logic [smvl_pkg::OUT_TDATA_W-1:0]       out_tdata_r, out_tdata_nxt;

  // datapath terms
  logic signed [smvl_pkg::MUL_AW-1:0]     s_cur;
  logic [31:0]                            gains;
  logic [smvl_pkg::LIM_W-1:0]             lim;
  logic signed [smvl_pkg::MUL_PW-1:0]     psh;
  logic signed [smvl_pkg::LAW_W-1:0]      law_term;
  logic signed [smvl_pkg::U_W-1:0]        u_sum;
  logic signed [smvl_pkg::U_W-1:0]        lim_u;
  logic signed [smvl_pkg::VEL_W-1:0]      v_res;
  logic signed [smvl_pkg::SURF_W-1:0]     quo_s;
  logic signed [smvl_pkg::SURF_W-1:0]     deriv;
  logic signed [smvl_pkg::SURF_W-1:0]     surf_sum;
  logic signed [EW-1:0]                   prev_use;
  logic signed [smvl_pkg::MUL_PW-1:0]     prod_mag;

  always_comb begin
    case (axis_r)
      smvl_pkg::AX_FWD: begin
        s_cur = smvl_pkg::MUL_AW'(ex_r);
        gains = cfg.linear_gains;
        lim   = cfg.linear_lateral_limits[31] ? '1 : cfg.linear_lateral_limits[30:16];
      end
      smvl_pkg::AX_LAT: begin
        s_cur = smvl_pkg::MUL_AW'(ey_r);
        gains = cfg.lateral_gains;
        lim   = cfg.linear_lateral_limits[15] ? '1 : cfg.linear_lateral_limits[14:0];
      end
      default: begin
        s_cur = s_ang_r;
        gains = cfg.angular_gains;
        lim   = cfg.angular_limit;
      end
    endcase
  end

  always_comb begin
    psh      = mul_prod >>> smvl_pkg::FRACTION_BITS;
    law_term = signed'(psh[smvl_pkg::LAW_W-1:0]);
    u_sum    = smvl_pkg::U_W'(t1_r) + smvl_pkg::U_W'(law_term);
    lim_u    = signed'(smvl_pkg::U_W'(lim));
    if (u_sum > lim_u)
      v_res = smvl_pkg::VEL_W'(lim_u);
    else if (u_sum < -lim_u)
      v_res = smvl_pkg::VEL_W'(-lim_u);
    else
      v_res = u_sum[smvl_pkg::VEL_W-1:0];
    quo_s    = signed'(smvl_pkg::SURF_W'(div_quo));
    deriv    = neg_r ? -quo_s : quo_s;
    surf_sum = deriv + smvl_pkg::SURF_W'(slope_r);
    prev_use = (armed_r || in_tuser) ? in_ey : prev_r;
    prod_mag = mul_prod[smvl_pkg::MUL_PW-1] ? -mul_prod : mul_prod;
  end

  // operand selection
  always_comb begin
    mul_a   = s_cur;
    mul_b   = '0;
    div_num = num_mag_r;
    div_den = dt_r;
    case (state_r)
      smvl_pkg::ST_SLOPE: begin
        mul_a = smvl_pkg::MUL_AW'(ey_r);
        mul_b = smvl_pkg::MUL_BW'(cfg.surface_slope);
      end
      smvl_pkg::ST_DERIV: begin
        mul_a = smvl_pkg::MUL_AW'(diff_r);
        mul_b = smvl_pkg::MICRO_SCALE;
      end
      smvl_pkg::ST_LAW_Q: mul_b = smvl_pkg::MUL_BW'(cfg.boundary_reciprocal);
      smvl_pkg::ST_LAW_E: mul_b = smvl_pkg::MUL_BW'(gains[15:0]);
      smvl_pkg::ST_LAW_K: begin
        mul_a = smvl_pkg::MUL_AW'(q_r);
        mul_b = smvl_pkg::MUL_BW'(gains[31:16]);
      end
      smvl_pkg::ST_WRAP: begin
        div_num = smvl_pkg::DIV_NW'(wrap_t_r);
        div_den = smvl_pkg::DIV_DW'(smvl_pkg::PERIOD);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    axis_nxt       = axis_r;
    issued_nxt     = issued_r;
    armed_nxt      = armed_r;
    prev_nxt       = prev_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    ex_nxt         = ex_r;
    ey_nxt         = ey_r;
    dt_nxt         = dt_r;
    diff_nxt       = diff_r;
    wrap_t_nxt     = wrap_t_r;
    s_ang_nxt      = s_ang_r;
    slope_nxt      = slope_r;
    neg_nxt        = neg_r;
    num_mag_nxt    = num_mag_r;
    q_nxt          = q_r;
    t1_nxt         = t1_r;
    vf_nxt         = vf_r;
    vl_nxt         = vl_r;
    va_nxt         = va_r;
    out_tdata_nxt  = out_tdata_r;
    mul_start      = 1'b0;
    div_start      = 1'b0;
    in_tready      = 1'b0;
    case (state_r)
      smvl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ex_nxt     = in_ex;
          ey_nxt     = in_ey;
          dt_nxt     = (in_dt < smvl_pkg::DT_MIN) ? smvl_pkg::DT_MIN : in_dt;
          diff_nxt   = (EW+1)'(in_ey) - (EW+1)'(prev_use);
          wrap_t_nxt = smvl_pkg::WRAP_W'(smvl_pkg::WRAP_BASE) - smvl_pkg::WRAP_W'(in_eh);
          prev_nxt   = in_ey;
          armed_nxt  = 1'b0;
          vl_nxt     = '0;
          axis_nxt   = smvl_pkg::AX_FWD;
          issued_nxt = 1'b0;
          state_nxt  = cfg.robot_mode ? smvl_pkg::ST_WRAP : smvl_pkg::ST_SLOPE;
        end
      end
      smvl_pkg::ST_WRAP: begin
        div_start  = !issued_r;
        issued_nxt = 1'b1;
        if (div_done) begin
          s_ang_nxt  = smvl_pkg::S_ANG_W'(smvl_pkg::PI_Q) - smvl_pkg::S_ANG_W'(div_rem);
          issued_nxt = 1'b0;
          state_nxt  = smvl_pkg::ST_LAW_Q;
        end
      end
      smvl_pkg::ST_SLOPE: begin
        mul_start  = !issued_r;
        issued_nxt = 1'b1;
        if (mul_done) begin
          slope_nxt  = law_term;
          issued_nxt = 1'b0;
          state_nxt  = smvl_pkg::ST_DERIV;
        end
      end
      smvl_pkg::ST_DERIV: begin
        mul_start  = !issued_r;
        issued_nxt = 1'b1;
        if (mul_done) begin
          neg_nxt     = mul_prod[smvl_pkg::MUL_PW-1];
          num_mag_nxt = prod_mag[smvl_pkg::DIV_NW-1:0];
          issued_nxt  = 1'b0;
          state_nxt   = smvl_pkg::ST_DIVIDE;
        end
      end
      smvl_pkg::ST_DIVIDE: begin
        div_start  = !issued_r;
        issued_nxt = 1'b1;
        if (div_done) begin
          issued_nxt = 1'b0;
          state_nxt  = smvl_pkg::ST_SURF;
        end
      end
      smvl_pkg::ST_SURF: begin
        if (surf_sum > smvl_pkg::SA_MAX)
          s_ang_nxt = smvl_pkg::SA_MAX[smvl_pkg::S_ANG_W-1:0];
        else if (surf_sum < smvl_pkg::SA_MIN)
          s_ang_nxt = smvl_pkg::SA_MIN[smvl_pkg::S_ANG_W-1:0];
        else
          s_ang_nxt = surf_sum[smvl_pkg::S_ANG_W-1:0];
        state_nxt = smvl_pkg::ST_LAW_Q;
      end
      smvl_pkg::ST_LAW_Q: begin
        mul_start  = !issued_r;
        issued_nxt = 1'b1;
        if (mul_done) begin
          if (psh > smvl_pkg::P_ONE)
            q_nxt = smvl_pkg::QW'(smvl_pkg::ONE_Q);
          else if (psh < smvl_pkg::P_MONE)
            q_nxt = smvl_pkg::QW'(-smvl_pkg::ONE_Q);
          else
            q_nxt = psh[smvl_pkg::QW-1:0];
          issued_nxt = 1'b0;
          state_nxt  = smvl_pkg::ST_LAW_E;
        end
      end
      smvl_pkg::ST_LAW_E: begin
        mul_start  = !issued_r;
        issued_nxt = 1'b1;
        if (mul_done) begin
          t1_nxt     = law_term;
          issued_nxt = 1'b0;
          state_nxt  = smvl_pkg::ST_LAW_K;
        end
      end
      smvl_pkg::ST_LAW_K: begin
        mul_start  = !issued_r;
        issued_nxt = 1'b1;
        if (mul_done) begin
          issued_nxt = 1'b0;
          case (axis_r)
            smvl_pkg::AX_FWD: begin
              vf_nxt    = v_res;
              axis_nxt  = cfg.robot_mode ? smvl_pkg::AX_LAT : smvl_pkg::AX_ANG;
              state_nxt = smvl_pkg::ST_LAW_Q;
            end
            smvl_pkg::AX_LAT: begin
              vl_nxt    = v_res;
              axis_nxt  = smvl_pkg::AX_ANG;
              state_nxt = smvl_pkg::ST_LAW_Q;
            end
            default: begin
              va_nxt    = v_res;
              state_nxt = smvl_pkg::ST_DONE;
            end
          endcase
        end
      end
      smvl_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {s_ang_r,
                            cfg.robot_mode ? ey_r : {EW{1'b0}},
                            ex_r, va_r, vl_r, vf_r};
          state_nxt      = smvl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smvl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= smvl_pkg::ST_IDLE;
      axis_r       <= smvl_pkg::AX_FWD;
      issued_r     <= 1'b0;
      armed_r      <= 1'b1;
      prev_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      axis_r       <= axis_nxt;
      issued_r     <= issued_nxt;
      armed_r      <= armed_nxt;
      prev_r       <= prev_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    dt_r        <= dt_nxt;
    diff_r      <= diff_nxt;
    wrap_t_r    <= wrap_t_nxt;
    s_ang_r     <= s_ang_nxt;
    slope_r     <= slope_nxt;
    neg_r       <= neg_nxt;
    num_mag_r   <= num_mag_nxt;
    q_r         <= q_nxt;
    t1_r        <= t1_nxt;
    vf_r        <= vf_nxt;
    vl_r        <= vl_nxt;
    va_r        <= va_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import smvl_pkg::*;

  localparam longint HALF_TURN = 12868;  // round(pi * 2^12)
  localparam longint S_ANG_HI = 8388607;
  localparam longint S_ANG_LO = -8388608;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 600;
  localparam int RANDOM_PHASES = 10;
  localparam int TICKS_PER_PHASE = 68;

  typedef struct packed {
    logic [15:0] ex;
    logic [15:0] ey;
    logic [15:0] eh;
    logic [19:0] dt;
    logic        np;
  } tick_t;

  typedef struct packed {
    logic [15:0] v_fwd;
    logic [15:0] v_lat;
    logic [15:0] v_ang;
    logic [15:0] s_fwd;
    logic [15:0] s_lat;
    logic [23:0] s_ang;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  wire in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  wire out_tvalid;
  logic out_tready = 1'b0;
  wire [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  wire [CFG_DW-1:0] cfg_prdata;
  wire cfg_pready;

  // register shadow and tick-to-tick state
  logic mode_r = RST_ROBOT_MODE;
  logic [15:0] slope_r = RST_SURFACE_SLOPE;
  logic [31:0] lin_gains_r = RST_LINEAR_GAINS;
  logic [31:0] lat_gains_r = RST_LATERAL_GAINS;
  logic [31:0] ang_gains_r = RST_ANGULAR_GAINS;
  logic [15:0] recip_r = RST_BOUNDARY_RECP;
  logic [31:0] limits_r = RST_LIN_LAT_LIMS;
  logic [14:0] ang_limit_r = RST_ANGULAR_LIMIT;
  longint last_lateral = 0;
  logic armed = 1'b1;

  tick_t ticks_to_send[$];
  command_t commands_due[$];
  int ticks_queued = 0;
  int ticks_taken = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int take_gap = 0;
  int hold_left = 0;
  bit steady_send = 1'b0;
  bit steady_take = 1'b0;
  bit in_beat = 1'b0;
  bit out_beat = 1'b0;
  tick_t next_tick;
  tick_t seen_tick;
  command_t want;
  command_t got;

  sliding_mode_velocity_law dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint floor_q(longint v);
    return v >>> FRACTION_BITS;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint axis_command(longint s, logic [31:0] gains, logic [15:0] limit);
    longint lim;
    longint sat_term;
    lim = (limit > 16'd32767) ? 32767 : longint'(limit);
    sat_term = clamp(floor_q(s * longint'(recip_r)), -ONE_Q, ONE_Q);
    return clamp(floor_q(longint'(gains[15:0]) * s) + floor_q(longint'(gains[31:16]) * sat_term),
                 -lim, lim);
  endfunction

  function automatic command_t velocity_law(tick_t t);
    command_t c;
    longint ex, ey, eh, dt, vf, vl, va, sl, sa, r;
    ex = longint'($signed(t.ex));
    ey = longint'($signed(t.ey));
    eh = longint'($signed(t.eh));
    dt = (t.dt < 20'd100) ? 100 : longint'(t.dt);
    if (armed || t.np) last_lateral = ey;
    armed = 1'b0;
    vf = axis_command(ex, lin_gains_r, limits_r[31:16]);
    if (mode_r) begin
      sl = ey;
      r = (HALF_TURN - eh) % (2 * HALF_TURN);
      if (r < 0) r += 2 * HALF_TURN;
      sa = HALF_TURN - r;
      vl = axis_command(sl, lat_gains_r, limits_r[15:0]);
    end else begin
      sa = clamp((ey - last_lateral) * 1000000 / dt + floor_q(longint'(slope_r) * ey),
                 S_ANG_LO, S_ANG_HI);
      sl = 0;
      vl = 0;
    end
    va = axis_command(sa, ang_gains_r, {1'b0, ang_limit_r});
    last_lateral = ey;
    c.v_fwd = vf[15:0];
    c.v_lat = vl[15:0];
    c.v_ang = va[15:0];
    c.s_fwd = t.ex;
    c.s_lat = sl[15:0];
    c.s_ang = sa[23:0];
    return c;
  endfunction

  task automatic note_error(input string what);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_v, input logic [23:0] act_v);
    if (exp_v !== act_v) note_error($sformatf("%s expected %h got %h", name, exp_v, act_v));
  endtask

  task automatic reg_access(input logic write, input reg_idx_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] kept;
    logic [31:0] readback;
    case (idx)
      REG_ROBOT_MODE: begin
        mode_r = value[0];
        kept = {31'b0, value[0]};
      end
      REG_SURFACE_SLOPE: begin
        slope_r = value[15:0];
        kept = {16'b0, value[15:0]};
      end
      REG_LINEAR_GAINS: begin
        lin_gains_r = value;
        kept = value;
      end
      REG_LATERAL_GAINS: begin
        lat_gains_r = value;
        kept = value;
      end
      REG_ANGULAR_GAINS: begin
        ang_gains_r = value;
        kept = value;
      end
      REG_BOUNDARY_RECP: begin
        recip_r = value[15:0];
        kept = {16'b0, value[15:0]};
      end
      REG_LIN_LAT_LIMS: begin
        limits_r = value;
        kept = value;
      end
      REG_ANGULAR_LIMIT: begin
        ang_limit_r = value[14:0];
        kept = {17'b0, value[14:0]};
      end
    endcase
    reg_access(1'b1, idx, value, readback);
    reg_access(1'b0, idx, '0, readback);
    if (readback !== kept)
      note_error($sformatf("register %s read %h, wrote %h", idx.name(), readback, kept));
  endtask

  task automatic add_tick(input int ex, input int ey, input int eh, input int dt, input bit np);
    tick_t t;
    t.ex = ex[15:0];
    t.ey = ey[15:0];
    t.eh = eh[15:0];
    t.dt = dt[19:0];
    t.np = np;
    ticks_to_send.push_back(t);
    ticks_queued++;
  endtask

  task automatic drain();
    while (ticks_taken != ticks_queued || commands_due.size() != 0) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_beat) begin
      end else if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (ticks_to_send.size() != 0) begin
        next_tick = ticks_to_send.pop_front();
        in_tdata <= {4'b0, next_tick.dt, next_tick.eh, next_tick.ey, next_tick.ex};
        in_tuser <= next_tick.np;
        in_tvalid <= 1'b1;
        send_gap = steady_send ? 0 : $urandom_range(0, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_beat) take_gap = steady_take ? 0 : $urandom_range(0, 7);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (take_gap > 0) begin
        out_tready <= 1'b0;
        take_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      in_beat = in_tvalid && in_tready;
      out_beat = out_tvalid && out_tready;
      if (in_beat) begin
        seen_tick = {in_tdata[15:0], in_tdata[31:16], in_tdata[47:32], in_tdata[67:48], in_tuser};
        commands_due.push_back(velocity_law(seen_tick));
        ticks_taken++;
      end
      if (out_beat) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
               out_tdata[79:64], out_tdata[103:80]};
        if (commands_due.size() == 0) begin
          note_error("result beat with no tick outstanding");
        end else begin
          want = commands_due.pop_front();
          check_field("velocity_forward", want.v_fwd, got.v_fwd);
          check_field("velocity_lateral", want.v_lat, got.v_lat);
          check_field("velocity_angular", want.v_ang, got.v_ang);
          check_field("surface_forward", want.s_fwd, got.s_fwd);
          check_field("surface_lateral", want.s_lat, got.s_lat);
          check_field("surface_angular", want.s_ang, got.s_ang);
        end
      end
      if (in_beat || out_beat || (cfg_psel && cfg_penable && cfg_pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    int ex, eh, dt, kind, trail_ey;
    logic [31:0] value;
    trail_ey = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, differential; first tick arms the derivative
    add_tick(0, 0, 0, 0, 1'b0);
    add_tick(32767, 100, 0, 99, 1'b0);
    add_tick(-32768, -100, 0, 100, 1'b0);
    add_tick(4096, 32767, 32767, 1048575, 1'b0);
    add_tick(-4096, -32768, -32768, 100, 1'b0);
    add_tick(1, 32767, 0, 100, 1'b0);
    add_tick(-1, 500, 0, 20000, 1'b1);
    add_tick(2, -500, 0, 20000, 1'b0);
    drain();

    // omni: heading wrap around +/- pi
    write_reg(REG_ROBOT_MODE, 32'd1);
    add_tick(0, 0, 12868, 50000, 1'b0);
    add_tick(0, 0, -12868, 50000, 1'b0);
    add_tick(32767, -32768, 12869, 50000, 1'b0);
    add_tick(-32768, 32767, -32768, 50000, 1'b0);
    add_tick(100, -100, 32767, 0, 1'b1);
    drain();

    // all-ones settings, zero boundary reciprocal, limits above full scale
    for (int i = 0; i < 8; i++)
      write_reg(reg_idx_t'(i), (reg_idx_t'(i) == REG_BOUNDARY_RECP) ? 32'd0 : 32'hFFFF_FFFF);
    add_tick(32767, 32767, 32767, 100, 1'b0);
    add_tick(-32768, -32768, -32768, 100, 1'b0);
    add_tick(12345, -2000, 20000, 5000, 1'b0);
    drain();
    write_reg(REG_ROBOT_MODE, 32'd0);
    add_tick(32767, 32767, 0, 100, 1'b1);
    add_tick(-32768, -32768, 0, 100, 1'b0);
    add_tick(12345, -2000, 0, 5000, 1'b0);
    drain();

    // zero gains and limits, smallest reciprocal
    for (int i = 0; i < 8; i++)
      write_reg(reg_idx_t'(i), (reg_idx_t'(i) == REG_BOUNDARY_RECP) ? 32'd1 : 32'd0);
    add_tick(32767, -32768, 32767, 1048575, 1'b0);
    add_tick(-32768, 32767, -32768, 1, 1'b1);
    add_tick(4096, 4096, 4096, 100000, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < 8; i++) begin
        kind = $urandom_range(0, 7);
        if (kind == 0) value = 32'd0;
        else if (kind == 1) value = 32'hFFFF_FFFF;
        else if (kind < 5) value = $urandom;
        else value = $urandom & 32'h3FFF_3FFF;
        if (reg_idx_t'(i) == REG_ROBOT_MODE) value = p % 2;
        write_reg(reg_idx_t'(i), value);
      end
      steady_send = (p == 3);
      steady_take = (p == 3);
      if (p == 6) begin
        @(posedge clk);
        hold_left = LONG_HOLD;
      end
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          // smooth tracking within a few boundary widths
          ex = int'($urandom_range(0, 16384)) - 8192;
          trail_ey = trail_ey + int'($urandom_range(0, 1024)) - 512;
          eh = int'($urandom_range(0, 40000)) - 20000;
          dt = $urandom_range(5000, 100000);
        end else begin
          ex = $urandom;
          trail_ey = $urandom;
          eh = $urandom;
          dt = (kind == 9) ? $urandom_range(0, 150) : $urandom;
        end
        add_tick(ex, trail_ey, eh, dt, $urandom_range(0, 11) == 0);
      end
      drain();
    end
    steady_send = 1'b0;
    steady_take = 1'b0;

    repeat (200) @(posedge clk);
    if (commands_due.size() != 0)
      note_error($sformatf("%0d results never arrived", commands_due.size()));
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
